// ----- sv/assert_macros.svh -----
// Assertion macros shared by the checker files of this project.
// Each macro samples on clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold too.
`define CHK_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the cycle after.
`define CHK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/lltd_pkg.sv -----
// Shared types and constants of the least-loaded task dispatcher.
// No dependencies; every file but assert_macros.svh refers to it by scoped names.
package lltd_pkg;

  localparam int NODE_NUM = 16;                     // table entries
  localparam int ID_W     = 4;                      // node id width
  localparam int CNT_W    = 5;                      // scan index, holds NODE_NUM
  localparam int TASK_W   = 16;
  localparam int LOAD_W   = 8;
  localparam int NCFG_W   = 5;                      // node_count register width

  localparam logic [TASK_W-1:0] TASK_MAX = '1;
  localparam logic [LOAD_W-1:0] LOAD_MAX = '1;
  localparam logic [NCFG_W-1:0] NCFG_RESET = NCFG_W'(NODE_NUM);

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam logic REG_NODE_COUNT = 1'b0;           // register index

  typedef enum logic [1:0] {
    OP_SPAWN      = 2'd0,
    OP_UPDATE     = 2'd1,
    OP_ACTIVATE   = 2'd2,
    OP_DEACTIVATE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_ROUTED   = 2'd0,
    KIND_ACTIVE   = 2'd1,
    KIND_INACTIVE = 2'd2,
    KIND_NONE     = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ROUTE,
    ST_NOTIFY
  } state_t;

  typedef struct packed {
    logic accept;       // latch the request and apply its immediate writes
    logic scan_step;    // compare one entry against the best so far
    logic route;        // emit the spawn result and bump the chosen count
    logic notify_step;  // emit a notice for one entry if active, advance
    logic commit;       // finish an activate: set flag, clear count and load
  } ctrl_cmd_t;

  typedef struct packed {
    op_t  in_op;
    logic in_range;
    logic idx_end;
    logic cur_active;
    logic out_free;
  } dp_status_t;

endpackage

// ----- sv/lltd_datapath.sv -----
// Datapath of the dispatcher: node table, scan index, best-node tracker
// and the result register. Uses lltd_pkg; driven by lltd_ctrl commands.
module lltd_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  lltd_pkg::ctrl_cmd_t                 cmd,
  output lltd_pkg::dp_status_t                status,
  input  logic [lltd_pkg::NCFG_W-1:0]         node_count,
  input  logic [1:0]                          opcode,
  input  logic [lltd_pkg::ID_W-1:0]           node_id,
  input  logic [lltd_pkg::TASK_W-1:0]         new_task_count,
  input  logic [lltd_pkg::LOAD_W-1:0]         new_cpu_load,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          kind,
  output logic [lltd_pkg::ID_W-1:0]           target_node,
  output logic [lltd_pkg::ID_W-1:0]           about_node,
  output logic                                last
);

  logic [lltd_pkg::TASK_W-1:0] task_counts [lltd_pkg::NODE_NUM];
  logic [lltd_pkg::LOAD_W-1:0] cpu_loads   [lltd_pkg::NODE_NUM];
  logic [lltd_pkg::NODE_NUM-1:0] active_flags;

  lltd_pkg::op_t               op_r;
  logic [lltd_pkg::ID_W-1:0]   id_r;
  logic [lltd_pkg::CNT_W-1:0]  idx;
  logic                        found;
  logic [lltd_pkg::ID_W-1:0]   best_id;
  logic [lltd_pkg::TASK_W-1:0] best_count;

  logic [lltd_pkg::CNT_W-1:0]    span;
  logic [lltd_pkg::ID_W-1:0]     cur;
  logic [lltd_pkg::TASK_W-1:0]   cur_count;
  logic                          better;
  logic [lltd_pkg::NODE_NUM-1:0] rest_mask;
  logic                          notice_last;
  logic                          emit_notice;
  lltd_pkg::kind_t               notice_kind;

  always_comb begin
    if (node_count > lltd_pkg::CNT_W'(lltd_pkg::NODE_NUM)) begin
      span = lltd_pkg::CNT_W'(lltd_pkg::NODE_NUM);
    end else begin
      span = node_count;
    end
  end

  assign cur       = idx[lltd_pkg::ID_W-1:0];
  assign cur_count = task_counts[cur];
  assign better    = active_flags[cur] && (!found || (cur_count < best_count));

  // Active peers above the current index decide whether this notice is last.
  always_comb begin
    for (int j = 0; j < lltd_pkg::NODE_NUM; j++) begin
      rest_mask[j] = (lltd_pkg::CNT_W'(j) > idx) && (lltd_pkg::CNT_W'(j) < span);
    end
  end
  assign notice_last = ~|(active_flags & rest_mask);
  assign emit_notice = cmd.notify_step && active_flags[cur];
  assign notice_kind = (op_r == lltd_pkg::OP_ACTIVATE) ? lltd_pkg::KIND_ACTIVE
                                                      : lltd_pkg::KIND_INACTIVE;

  assign status.in_op      = lltd_pkg::op_t'(opcode);
  assign status.in_range   = ({1'b0, node_id} < span);
  assign status.idx_end    = (idx >= span);
  assign status.cur_active = active_flags[cur];
  assign status.out_free   = !out_valid || !out_stall;

  // Request capture, scan index and best-node tracker.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r  <= lltd_pkg::op_t'(opcode);
      id_r  <= node_id;
      idx   <= '0;
      found <= 1'b0;
    end else if (cmd.scan_step) begin
      idx <= idx + 1'b1;
      if (better) begin
        found      <= 1'b1;
        best_id    <= cur;
        best_count <= cur_count;
      end
    end else if (cmd.notify_step) begin
      idx <= idx + 1'b1;
    end
  end

  // Node table.
  always_ff @(posedge clk) begin
    if (rst) begin
      active_flags <= '0;
      for (int j = 0; j < lltd_pkg::NODE_NUM; j++) begin
        task_counts[j] <= lltd_pkg::TASK_MAX;
        cpu_loads[j]   <= lltd_pkg::LOAD_MAX;
      end
    end else if (cmd.accept && status.in_range &&
                 (status.in_op == lltd_pkg::OP_UPDATE)) begin
      task_counts[node_id] <= new_task_count;
      cpu_loads[node_id]   <= new_cpu_load;
    end else if (cmd.accept && status.in_range &&
                 (status.in_op == lltd_pkg::OP_DEACTIVATE)) begin
      active_flags[node_id] <= 1'b0;
    end else if (cmd.commit && (op_r == lltd_pkg::OP_ACTIVATE)) begin
      active_flags[id_r] <= 1'b1;
      task_counts[id_r]  <= '0;
      cpu_loads[id_r]    <= '0;
    end else if (cmd.route && found && (best_count != lltd_pkg::TASK_MAX)) begin
      task_counts[best_id] <= best_count + 1'b1;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.route || emit_notice) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.route) begin
      kind        <= found ? lltd_pkg::KIND_ROUTED : lltd_pkg::KIND_NONE;
      target_node <= found ? best_id : '0;
      about_node  <= '0;
      last        <= 1'b1;
    end else if (emit_notice) begin
      kind        <= notice_kind;
      target_node <= cur;
      about_node  <= id_r;
      last        <= notice_last;
    end
  end

endmodule

// ----- sv/lltd_ctrl.sv -----
// Controller state machine of the dispatcher: sequences scan, route and
// notice phases. Uses lltd_pkg; commands lltd_datapath.
module lltd_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  lltd_pkg::dp_status_t  status,
  output lltd_pkg::ctrl_cmd_t   cmd
);

  lltd_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lltd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      lltd_pkg::ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
        if (in_valid) begin
          unique case (status.in_op)
            lltd_pkg::OP_SPAWN:  state_next = lltd_pkg::ST_SCAN;
            lltd_pkg::OP_UPDATE: state_next = lltd_pkg::ST_IDLE;
            default: begin
              state_next = status.in_range ? lltd_pkg::ST_NOTIFY : lltd_pkg::ST_IDLE;
            end
          endcase
        end
      end
      lltd_pkg::ST_SCAN: begin
        if (status.idx_end) begin
          state_next = lltd_pkg::ST_ROUTE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      lltd_pkg::ST_ROUTE: begin
        if (status.out_free) begin
          cmd.route  = 1'b1;
          state_next = lltd_pkg::ST_IDLE;
        end
      end
      lltd_pkg::ST_NOTIFY: begin
        if (status.idx_end) begin
          cmd.commit = 1'b1;
          state_next = lltd_pkg::ST_IDLE;
        end else if (!status.cur_active || status.out_free) begin
          cmd.notify_step = 1'b1;
        end
      end
      default: state_next = lltd_pkg::ST_IDLE;
    endcase
  end

endmodule

// ----- sv/least_loaded_task_dispatcher.sv -----
// Top level of the least-loaded task dispatcher: configuration register,
// controller and datapath. Uses lltd_pkg, lltd_ctrl and lltd_datapath.
//
// The block keeps a table of 16 worker nodes (active flag, task count,
// cpu load) and takes one request at a time. A spawn request scans the
// table one entry per clock through a single comparator, then issues one
// result: the active node with the lowest task count (lowest id on a tie),
// whose count is bumped with saturation, or a no-active-node result. A
// spawn then waits in the route state until the output is free. A status
// update overwrites a node's count and load in the accept cycle and gives
// no result. Activate and deactivate walk the table the same way and
// issue one notice per active peer, flagged last on the final one; the
// walk holds on an active peer while the output is stalled. Activate
// notifies the peers as they were before (the node itself included if it
// was already active) and then sets the node active with a cleared count
// and load; deactivate drops the flag first. Requests for a node id at or
// beyond node_count are dropped without result. The result register lets
// the next request be accepted while a result waits. Register node_count
// sits at byte address 0 of the APB port (reset 16, values above 16 act
// as 16); write it only while the block is idle.
module least_loaded_task_dispatcher (
  input  logic                                 clk,
  input  logic                                 rst,
  // request channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           opcode,
  input  logic [lltd_pkg::ID_W-1:0]            node_id,
  input  logic [lltd_pkg::TASK_W-1:0]          new_task_count,
  input  logic [lltd_pkg::LOAD_W-1:0]          new_cpu_load,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [1:0]                           kind,
  output logic [lltd_pkg::ID_W-1:0]            target_node,
  output logic [lltd_pkg::ID_W-1:0]            about_node,
  output logic                                 last,
  // configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [lltd_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [lltd_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [lltd_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                 pready
);

  logic [lltd_pkg::NCFG_W-1:0] node_count;
  logic                        reg_hit;
  lltd_pkg::ctrl_cmd_t         cmd;
  lltd_pkg::dp_status_t        status;

  // Only one register: the word index is the address bit above the byte
  // offset; anything else reads as zero and ignores writes.
  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == lltd_pkg::REG_NODE_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= lltd_pkg::NCFG_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      node_count <= pwdata[lltd_pkg::NCFG_W-1:0];
    end
  end

  assign prdata = reg_hit ? lltd_pkg::APB_DATA_W'(node_count) : '0;

  lltd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  lltd_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .node_count     (node_count),
    .opcode         (opcode),
    .node_id        (node_id),
    .new_task_count (new_task_count),
    .new_cpu_load   (new_cpu_load),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .kind           (kind),
    .target_node    (target_node),
    .about_node     (about_node),
    .last           (last)
  );

endmodule

// ----- sv/lltd_checker.sv -----
// Port-level checker for the dispatcher, bound to the top level.
// Uses lltd_pkg and the macros in assert_macros.svh.
`include "assert_macros.svh"

module lltd_port_checks (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic [1:0]                   opcode,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [1:0]                   kind,
  input logic [lltd_pkg::ID_W-1:0]    target_node,
  input logic [lltd_pkg::ID_W-1:0]    about_node,
  input logic                         last
);

  `CHK_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(kind) && $stable(target_node) && $stable(about_node) && $stable(last),
    "result changed while stalled")
  `CHK_SAME(a_none_zero, out_valid && (kind == lltd_pkg::KIND_NONE),
    (target_node == '0) && (about_node == '0) && last,
    "no-active result not zero or not last")
  `CHK_SAME(a_route_last, out_valid && (kind == lltd_pkg::KIND_ROUTED),
    last && (about_node == '0), "routed spawn result malformed")
  `CHK_NEXT(a_spawn_busy, in_valid && !in_stall && (opcode == lltd_pkg::OP_SPAWN),
    in_stall, "request accepted during spawn scan")

endmodule

bind least_loaded_task_dispatcher lltd_port_checks u_lltd_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .opcode      (opcode),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .kind        (kind),
  .target_node (target_node),
  .about_node  (about_node),
  .last        (last)
);
